@@ rtl/serial_command_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Serial command frame parser: assertion macros
// Shared concurrent assertion helpers for the parser's checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

// property checked while out of reset
`define SCFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define SCFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/scfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Types and constants shared by the parser core and the top level.
// ----------------------------------------------------------------------------
package scfp_pkg;

   localparam int BYTE_W    = 8;
   localparam int PAYLOAD_W = 48;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_FIRST  = 3'd0,
      CSR_HEADER_SECOND = 3'd1,
      CSR_TYPE_VELOCITY = 3'd2,
      CSR_TYPE_GAINS    = 3'd3,
      CSR_TYPE_SETTINGS = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_SIZE  = 3'd2,
      PH_TYPE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_VEL  = 2'd0,
      KIND_GAIN = 2'd1,
      KIND_SET  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
      logic [BYTE_W-1:0] type_velocity;
      logic [BYTE_W-1:0] type_gains;
      logic [BYTE_W-1:0] type_settings;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [PAYLOAD_W-1:0] payload;
   } result_type;

endpackage

@@ rtl/scfp_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser core
// Byte-at-a-time frame state machine with running checksum; flags a good
// velocity or gain frame on the byte that carries its checksum.
// ----------------------------------------------------------------------------
module scfp_parser #(
   parameter int PAYLOAD_BYTES = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             byte_valid,
   input  logic [scfp_pkg::BYTE_W-1:0]      rx_byte,
   input  scfp_pkg::cfg_type                cfg,
   output scfp_pkg::result_type             result
);
   import scfp_pkg::*;

   localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

   phase_type            phase_ff,      phase_in;
   logic [BYTE_W-1:0]    sum_ff,        sum_in;
   kind_type             kind_ff,       kind_in;
   logic [PAYLOAD_W-1:0] payload_ff,    payload_in;
   logic [CNT_W-1:0]     bytes_seen_ff, bytes_seen_in;
   logic [BYTE_W-1:0]    sum_add;

   assign sum_add = sum_ff + rx_byte;

   always_comb begin
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      kind_in       = kind_ff;
      payload_in    = payload_ff;
      bytes_seen_in = bytes_seen_ff;
      result        = '0;
      result.kind   = (kind_ff == KIND_GAIN);
      result.payload = payload_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEAD1: begin
               if (rx_byte == cfg.header_first) begin
                  sum_in   = rx_byte;
                  phase_in = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               // a miss is not retried as a first header
               if (rx_byte == cfg.header_second) begin
                  sum_in   = sum_add;
                  phase_in = PH_SIZE;
               end else begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_SIZE: begin
               sum_in   = sum_add;
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               sum_in        = sum_add;
               payload_in    = '0;
               bytes_seen_in = '0;
               phase_in      = PH_DATA;
               priority if (rx_byte == cfg.type_velocity) begin
                  kind_in = KIND_VEL;
               end else if (rx_byte == cfg.type_gains) begin
                  kind_in = KIND_GAIN;
               end else if (rx_byte == cfg.type_settings) begin
                  kind_in = KIND_SET;
               end else begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_DATA: begin
               sum_in     = sum_add;
               payload_in = {payload_ff[PAYLOAD_W-BYTE_W-1:0], rx_byte};
               if (bytes_seen_ff == CNT_LAST) begin
                  bytes_seen_in = '0;
                  // settings frames carry no checksum byte here
                  phase_in = (kind_ff == KIND_SET) ? PH_HEAD1 : PH_CHECK;
               end else begin
                  bytes_seen_in = bytes_seen_ff + 1'b1;
               end
            end
            PH_CHECK: begin
               result.valid = (rx_byte == sum_ff) && (kind_ff != KIND_SET);
               phase_in     = PH_HEAD1;
            end
            default: begin
               phase_in = PH_HEAD1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD1;
         kind_ff       <= KIND_VEL;
         bytes_seen_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         bytes_seen_ff <= bytes_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      payload_ff <= payload_in;
   end

endmodule

@@ rtl/serial_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser
// Recognises header/size/type/payload/checksum command frames in a byte
// stream and emits the kind and payload of every good velocity or gain frame.
// ----------------------------------------------------------------------------
// One byte is taken per clock while req_tready is high. The frame state
// machine and checksum update on the accepting edge, and a good checksum byte
// loads its result on that same edge into the output register, so rsp_tvalid
// rises in the next cycle, or, if that register is still full, into a skid
// stage behind it. req_tready only drops when both hold results that the sink
// has not taken. Results are at least PAYLOAD_BYTES + 5 bytes apart (eleven by
// default), so a sink that keeps up with one result per frame never stalls
// the input. Configuration writes take effect on the next byte.
module serial_command_frame_parser #(
   parameter int PAYLOAD_BYTES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // slave side: [7:0] rx_byte
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // master side: [47:0] payload
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [scfp_pkg::PAYLOAD_W-1:0]    rsp_tdata,
   // master side: [0] frame_kind
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_wen,
   input  logic [scfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]       csr_wdata
);
   import scfp_pkg::*;

   cfg_type              cfg_ff,        cfg_in;
   result_type           result;
   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic                 main_kind_ff,  main_kind_in;
   logic                 skid_kind_ff,  skid_kind_in;
   logic [PAYLOAD_W-1:0] main_data_ff,  main_data_in;
   logic [PAYLOAD_W-1:0] skid_data_ff,  skid_data_in;
   logic                 accept;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            CSR_TYPE_VELOCITY: cfg_in.type_velocity = csr_wdata;
            CSR_TYPE_GAINS:    cfg_in.type_gains    = csr_wdata;
            CSR_TYPE_SETTINGS: cfg_in.type_settings = csr_wdata;
            default: ;
         endcase
      end
   end

   scfp_parser #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .rx_byte    (req_tdata),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // output register with one skid entry behind it
   always_comb begin
      main_valid_in = main_valid_ff;
      main_kind_in  = main_kind_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_kind_in  = skid_kind_ff;
      skid_data_in  = skid_data_ff;
      if (main_valid_ff && rsp_tready) begin
         main_valid_in = 1'b0;
      end
      if (!main_valid_in && skid_valid_ff) begin
         main_valid_in = 1'b1;
         main_kind_in  = skid_kind_ff;
         main_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (result.valid) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_kind_in  = result.kind;
            main_data_in  = result.payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_kind_in  = result.kind;
            skid_data_in  = result.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= 8'd170;
         cfg_ff.header_second <= 8'd85;
         cfg_ff.type_velocity <= 8'd1;
         cfg_ff.type_gains    <= 8'd2;
         cfg_ff.type_settings <= 8'd3;
         main_valid_ff        <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         cfg_ff               <= cfg_in;
         main_valid_ff        <= main_valid_in;
         skid_valid_ff        <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_kind_ff <= main_kind_in;
      main_data_ff <= main_data_in;
      skid_kind_ff <= skid_kind_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid   = main_valid_ff;
   assign rsp_tdata    = main_data_ff;
   assign rsp_tuser[0] = main_kind_ff;

endmodule

@@ rtl/scfp_checker.sv @@
// ----------------------------------------------------------------------------
// Frame parser port checker
// Port-level properties of the parser's stream interfaces, bound to the top.
// ----------------------------------------------------------------------------
`include "serial_command_frame_parser_macros.svh"

module scfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [scfp_pkg::PAYLOAD_W-1:0]    rsp_tdata,
   input logic [0:0]                        rsp_tuser
);
   import scfp_pkg::*;

   `SCFP_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result changed")
   `SCFP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid,
      "result valid straight after reset")
   `SCFP_ASSERT(a_rsp_cause, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready), "result without a request")
   `SCFP_ASSERT(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid,
      "input stalled with no result pending")

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/sv/serial_command_frame_parser_checker.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser: stream checker
// Watches the request, result and register ports, tracks the frame state of
// the byte stream, and compares every result with the oldest expected frame.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_checker #(
   parameter int PAYLOAD_BYTES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [scfp_pkg::PAYLOAD_W-1:0]    rsp_tdata,
   input  logic [0:0]                        rsp_tuser,
   input  logic                              csr_wen,
   input  logic [scfp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]       csr_wdata,
   output int                                outstanding,
   output int                                failures,
   output int                                good_frames,
   output int                                gain_frames
);
   timeunit 1ns;
   timeprecision 1ps;
   import scfp_pkg::*;

   localparam cfg_type RESET_REGS = '{header_first: 8'd170, header_second: 8'd85,
                                      type_velocity: 8'd1, type_gains: 8'd2,
                                      type_settings: 8'd3};

   typedef struct packed {
      logic                 kind;
      logic [PAYLOAD_W-1:0] payload;
   } frame_result_type;

   frame_result_type     pending_frames[$];
   cfg_type              regs;
   phase_type            stage;
   kind_type             frame_kind;
   logic [7:0]           check_acc;
   logic [PAYLOAD_W-1:0] frame_body;
   int                   body_count;
   int                   fail_count;
   int                   good_count;
   int                   gain_count;

   task automatic track_frame_byte(input logic [7:0] b);
      frame_result_type done;
      case (stage)
         PH_HEAD1: begin
            if (b == regs.header_first) begin
               check_acc = b;
               stage     = PH_HEAD2;
            end
         end
         PH_HEAD2: begin
            // a miss here is dropped, never retried as a first header
            if (b == regs.header_second) begin
               check_acc += b;
               stage      = PH_SIZE;
            end else begin
               stage = PH_HEAD1;
            end
         end
         PH_SIZE: begin
            check_acc += b;
            stage      = PH_TYPE;
         end
         PH_TYPE: begin
            check_acc += b;
            frame_body = '0;
            body_count = 0;
            stage      = PH_DATA;
            if (b == regs.type_velocity) begin
               frame_kind = KIND_VEL;
            end else if (b == regs.type_gains) begin
               frame_kind = KIND_GAIN;
            end else if (b == regs.type_settings) begin
               frame_kind = KIND_SET;
            end else begin
               stage = PH_HEAD1;
            end
         end
         PH_DATA: begin
            check_acc += b;
            frame_body = {frame_body[PAYLOAD_W-9:0], b};
            if (body_count + 1 >= PAYLOAD_BYTES) begin
               body_count = 0;
               // settings frames carry no checksum byte
               stage = (frame_kind == KIND_SET) ? PH_HEAD1 : PH_CHECK;
            end else begin
               body_count++;
            end
         end
         PH_CHECK: begin
            if (b == check_acc && frame_kind != KIND_SET) begin
               done.kind    = (frame_kind == KIND_GAIN);
               done.payload = frame_body;
               pending_frames.push_back(done);
            end
            stage = PH_HEAD1;
         end
         default: begin
            stage = PH_HEAD1;
         end
      endcase
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         pending_frames.delete();
         regs       = RESET_REGS;
         stage      = PH_HEAD1;
         frame_kind = KIND_VEL;
         check_acc  = '0;
         frame_body = '0;
         body_count = 0;
         fail_count = 0;
         good_count = 0;
         gain_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               $error("unexpected result: frame_kind %0d payload %h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_frames.pop_front();
               if (rsp_tuser[0] !== want.kind) begin
                  $error("frame_kind mismatch: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== want.payload) begin
                  $error("payload mismatch: expected %h, got %h", want.payload, rsp_tdata);
                  fail_count++;
               end
               good_count++;
               if (want.kind) gain_count++;
            end
         end
         if (req_tvalid && req_tready) track_frame_byte(req_tdata);
         // register writes apply from the next byte on
         if (csr_wen) begin
            case (csr_idx_type'(csr_index))
               CSR_HEADER_FIRST:  regs.header_first  = csr_wdata;
               CSR_HEADER_SECOND: regs.header_second = csr_wdata;
               CSR_TYPE_VELOCITY: regs.type_velocity = csr_wdata;
               CSR_TYPE_GAINS:    regs.type_gains    = csr_wdata;
               CSR_TYPE_SETTINGS: regs.type_settings = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding <= pending_frames.size();
      failures    <= fail_count;
      good_frames <= good_count;
      gain_frames <= gain_count;
   end

endmodule

@@ tb/sv/serial_command_frame_parser_test.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser: testbench top
// Drives byte streams of good, corrupted and partial command frames under
// several register settings, with bursty input and a stalling result sink.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scfp_pkg::*;

   localparam int PAYLOAD_BYTES  = 6;
   localparam int FRAME_LEN      = PAYLOAD_BYTES + 5;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 115;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = CSR_IDX_W'(CSR_TYPE_SETTINGS + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP   = '1;
   localparam cfg_type RESET_REGS = '{header_first: 8'd170, header_second: 8'd85,
                                      type_velocity: 8'd1, type_gains: 8'd2,
                                      type_settings: 8'd3};

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [PAYLOAD_W-1:0]     rsp_tdata;
   logic [0:0]               rsp_tuser;
   logic                     csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index  = '0;
   logic [BYTE_W-1:0]        csr_wdata  = '0;

   int                       outstanding;
   int                       failures;
   int                       good_frames;
   int                       gain_frames;

   cfg_type                  regs_now;
   int                       bytes_sent;
   int                       burst_left;
   bit                       gaps_on;
   logic                     ready_steady = 1'b0;
   logic [15:0]              stall_pat;
   int                       pat_age;
   int                       idle_cycles;
   int                       settings_used;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   serial_command_frame_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   serial_command_frame_parser_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .failures    (failures),
      .good_frames (good_frames),
      .gain_frames (gain_frames)
   );

   // result sink: rotating stall pattern, reloaded now and then
   always @(posedge clock) begin
      if (reset) begin
         stall_pat <= 16'hB3C5;
         pat_age   <= 0;
      end else begin
         if (pat_age == 200) begin
            stall_pat <= 16'($urandom) | 16'h0001;
            pat_age   <= 0;
         end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
            pat_age   <= pat_age + 1;
         end
         rsp_tready <= stall_pat[0] | ready_steady;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // builds a whole frame for the current registers, sends the first 'length' bytes
   task automatic send_frame(input logic [7:0] type_code, input logic [63:0] body,
                             input logic [7:0] check_flip, input int length);
      logic [7:0] frame [0:FRAME_LEN-1];
      logic [7:0] sum;
      frame[0] = regs_now.header_first;
      frame[1] = regs_now.header_second;
      frame[2] = 8'($urandom);
      frame[3] = type_code;
      for (int i = 0; i < PAYLOAD_BYTES; i++) frame[4+i] = body[8*(PAYLOAD_BYTES-1-i) +: 8];
      sum = '0;
      for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame[i];
      frame[FRAME_LEN-1] = sum ^ check_flip;
      for (int i = 0; i < length; i++) send_byte(frame[i]);
   endtask

   function automatic logic [63:0] rand_body();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_traffic(input int count);
      int         stop;
      int         pick;
      logic [7:0] code;
      logic [7:0] junk;
      stop = bytes_sent + count;
      while (bytes_sent < stop) begin
         pick = $urandom_range(0, 99);
         code = ($urandom_range(0, 1) == 1) ? regs_now.type_gains : regs_now.type_velocity;
         if (pick < 30) begin
            send_frame(regs_now.type_velocity, rand_body(), 8'h00, FRAME_LEN);
         end else if (pick < 55) begin
            send_frame(regs_now.type_gains, rand_body(), 8'h00, FRAME_LEN);
         end else if (pick < 68) begin
            send_frame(regs_now.type_settings, rand_body(), 8'h00, FRAME_LEN - 1);
         end else if (pick < 76) begin
            // corrupted checksum
            send_frame(code, rand_body(), 8'($urandom_range(1, 255)), FRAME_LEN);
         end else if (pick < 82) begin
            do code = 8'($urandom);
            while (code == regs_now.type_velocity || code == regs_now.type_gains ||
                   code == regs_now.type_settings);
            send_frame(code, rand_body(), 8'h00, $urandom_range(4, FRAME_LEN));
         end else if (pick < 88) begin
            // cut short, the next request lands mid-frame
            send_frame(code, rand_body(), 8'h00, $urandom_range(1, FRAME_LEN - 1));
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            send_byte(regs_now.header_first);
            do junk = 8'($urandom); while (junk == regs_now.header_second);
            send_byte(junk);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (csr_idx_type'(idx))
         CSR_HEADER_FIRST:  regs_now.header_first  = val;
         CSR_HEADER_SECOND: regs_now.header_second = val;
         CSR_TYPE_VELOCITY: regs_now.type_velocity = val;
         CSR_TYPE_GAINS:    regs_now.type_gains    = val;
         CSR_TYPE_SETTINGS: regs_now.type_settings = val;
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type c);
      write_reg(CSR_TYPE_SETTINGS, c.type_settings);
      write_reg(CSR_HEADER_FIRST, c.header_first);
      // spare index, must leave everything alone
      write_reg(CSR_IDX_W'($urandom_range(CSR_IDX_TOP, CSR_IDX_SPARE)), 8'($urandom));
      write_reg(CSR_TYPE_GAINS, c.type_gains);
      write_reg(CSR_HEADER_SECOND, c.header_second);
      write_reg(CSR_TYPE_VELOCITY, c.type_velocity);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      cfg_type next_regs;
      regs_now      = RESET_REGS;
      bytes_sent    = 0;
      burst_left    = 0;
      settings_used = 1;
      gaps_on       = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: payload extremes, both result kinds, second header miss on a header value
      send_frame(regs_now.type_velocity, '1, 8'h00, FRAME_LEN);
      send_frame(regs_now.type_gains, '0, 8'h00, FRAME_LEN);
      send_byte(regs_now.header_first);
      send_byte(regs_now.header_first);
      gaps_on = 1'b1;
      random_traffic(PHASE_BYTES - 24);
      wait_idle();

      for (int p = 1; p <= 5; p++) begin
         case (p)
            1: next_regs = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80};
            2: next_regs = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F};
            // equal headers, velocity and gain codes overlap
            3: next_regs = '{8'h5A, 8'h5A, 8'h11, 8'h11, 8'h22};
            4: begin
               next_regs = cfg_type'({$urandom, $urandom});
               next_regs.type_settings = next_regs.type_gains;
            end
            default: next_regs = cfg_type'({$urandom, $urandom});
         endcase
         load_settings(next_regs);
         gaps_on = (p % 2 == 0);
         ready_steady <= (p == 3);
         random_traffic(PHASE_BYTES);
         wait_idle();
      end

      $display("Sent %0d bytes over %0d register settings with bursty input and sink stalls;",
               bytes_sent, settings_used);
      $display("%0d good frames checked, %0d of them gain frames.", good_frames, gain_frames);
      if (failures == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
